// ----- sv/brlt_pkg.sv -----
// Shared types and constants for the byte-range lock table.
`default_nettype none

package brlt_pkg;

   localparam int OFFSET_BITS    = 64;
   localparam int OWNER_ID_BITS  = 16;
   localparam int REQ_TDATA_BITS = 152;
   localparam int RSP_TDATA_BITS = 24;

   typedef logic [OWNER_ID_BITS-1:0]      owner_id_type;
   typedef logic signed [OFFSET_BITS-1:0] offset_type;

   typedef enum logic [1:0] {
      MODE_ACQUIRE     = 2'd0,
      MODE_RELEASE     = 2'd1,
      MODE_RELEASE_ALL = 2'd2,
      MODE_TEST        = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CONFLICT = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      status_type   status;
      owner_id_type blocker_id;
      logic         blocker_kind;
   } result_type;

   typedef struct packed {
      logic conflict;
      logic exact;
      logic same_owner;
   } match_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_RA_READ,
      ST_RA_CHECK,
      ST_RA_MOVE,
      ST_DONE
   } seq_state_type;

endpackage

`default_nettype wire

// ----- sv/brlt_store.sv -----
// Lock entry memory: one write port, one read port, registered read data.
`default_nettype none

module brlt_store #(
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 4,
   parameter int DATA_BITS = 145
) (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/brlt_match.sv -----
// Compare one stored lock entry against the pending request.
`default_nettype none

module brlt_match #(
   parameter int OWNER_BITS = 16,
   parameter int ENTRY_BITS = 145
) (
   input  wire logic                   req_kind,
   input  wire brlt_pkg::offset_type   req_first,
   input  wire brlt_pkg::offset_type   req_last,
   input  wire logic [OWNER_BITS-1:0]  req_key,
   input  wire logic [ENTRY_BITS-1:0]  slot_entry,
   output brlt_pkg::match_type         match
);

   localparam int OffBits = brlt_pkg::OFFSET_BITS;

   brlt_pkg::offset_type  slot_first;
   brlt_pkg::offset_type  slot_last;
   logic                  slot_kind;
   logic [OWNER_BITS-1:0] slot_owner;
   logic                  overlap;

   assign slot_last  = slot_entry[OffBits-1:0];
   assign slot_first = slot_entry[2*OffBits-1:OffBits];
   assign slot_kind  = slot_entry[2*OffBits];
   assign slot_owner = slot_entry[ENTRY_BITS-1:2*OffBits+1];

   // inclusive at both ends, signed offsets
   assign overlap = (slot_first <= req_last) && (req_first <= slot_last);

   always_comb begin
      match.conflict   = overlap && (req_kind || slot_kind);
      match.same_owner = (slot_owner == req_key);
      match.exact      = match.same_owner && (slot_first == req_first) &&
                         (slot_last == req_last);
   end

endmodule

`default_nettype wire

// ----- sv/brlt_seq.sv -----
// Request sequencer: scan, append, shift-down and release-all passes over the entry memory.
`default_nettype none

module brlt_seq #(
   parameter int DEPTH      = 16,
   parameter int OWNER_BITS = 16,
   parameter int ADDR_BITS  = 4,
   parameter int COUNT_BITS = 5,
   parameter int ENTRY_BITS = 145
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         idle,
   input  wire brlt_pkg::mode_type      req_mode,
   input  wire logic [OWNER_BITS-1:0]   req_key,
   input  wire logic                    req_kind,
   input  wire brlt_pkg::offset_type    req_first,
   input  wire brlt_pkg::offset_type    req_last,
   output logic                         rd_en,
   output logic [ADDR_BITS-1:0]         rd_addr,
   input  wire logic [ENTRY_BITS-1:0]   rd_data,
   output logic                         wr_en,
   output logic [ADDR_BITS-1:0]         wr_addr,
   output logic [ENTRY_BITS-1:0]        wr_data,
   output logic                         res_vld,
   input  wire logic                    res_rdy,
   output brlt_pkg::result_type         res
);

   localparam int OffBits = brlt_pkg::OFFSET_BITS;
   localparam int IdBits  = brlt_pkg::OWNER_ID_BITS;

   brlt_pkg::seq_state_type state_ff, state_in;
   logic [COUNT_BITS-1:0]   slot_count_ff, slot_count_in;
   logic [COUNT_BITS-1:0]   idx_ff, idx_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [ADDR_BITS-1:0]    chk_idx_ff, chk_idx_in;
   logic                    wr_vld_ff, wr_vld_in;
   logic [ADDR_BITS-1:0]    wr_idx_ff, wr_idx_in;
   brlt_pkg::result_type    res_ff, res_in;

   brlt_pkg::match_type     match;
   logic                    hit;
   logic [COUNT_BITS-1:0]   last_idx;
   logic [COUNT_BITS-1:0]   idx_prev;
   logic [ENTRY_BITS-1:0]   req_entry;
   logic [OWNER_BITS-1:0]   slot_owner;
   logic                    slot_kind;

   brlt_match #(
      .OWNER_BITS (OWNER_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_match (
      .req_kind   (req_kind),
      .req_first  (req_first),
      .req_last   (req_last),
      .req_key    (req_key),
      .slot_entry (rd_data),
      .match      (match)
   );

   assign req_entry  = {req_key, req_kind, req_first, req_last};
   assign slot_owner = rd_data[ENTRY_BITS-1:2*OffBits+1];
   assign slot_kind  = rd_data[2*OffBits];
   assign hit        = (req_mode == brlt_pkg::MODE_RELEASE) ? match.exact : match.conflict;
   assign last_idx   = slot_count_ff - COUNT_BITS'(1);
   assign idx_prev   = idx_ff - COUNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= brlt_pkg::ST_IDLE;
         slot_count_ff <= '0;
         chk_vld_ff    <= 1'b0;
         wr_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_count_ff <= slot_count_in;
         chk_vld_ff    <= chk_vld_in;
         wr_vld_ff     <= wr_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      chk_idx_ff <= chk_idx_in;
      wr_idx_ff  <= wr_idx_in;
      res_ff     <= res_in;
   end

   always_comb begin
      state_in      = state_ff;
      slot_count_in = slot_count_ff;
      idx_in        = idx_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      wr_vld_in     = wr_vld_ff;
      wr_idx_in     = wr_idx_ff;
      res_in        = res_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[ADDR_BITS-1:0];
      wr_en         = 1'b0;
      wr_addr       = wr_idx_ff;
      wr_data       = rd_data;
      res_vld       = 1'b0;
      idle          = 1'b0;

      case (state_ff)
         brlt_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               idx_in     = '0;
               chk_vld_in = 1'b0;
               wr_vld_in  = 1'b0;
               res_in     = '{brlt_pkg::STATUS_OK, '0, 1'b0};
               // mode is captured on this same edge, so branch on the state below
               state_in   = brlt_pkg::ST_SCAN;
            end
         end

         brlt_pkg::ST_SCAN: begin
            if (req_mode == brlt_pkg::MODE_RELEASE_ALL) begin
               state_in = brlt_pkg::ST_RA_READ;
            end else if (chk_vld_ff && hit) begin
               chk_vld_in = 1'b0;
               if (req_mode == brlt_pkg::MODE_RELEASE) begin
                  idx_in   = COUNT_BITS'(chk_idx_ff) + COUNT_BITS'(1);
                  state_in = brlt_pkg::ST_SHIFT;
               end else begin
                  res_in.status       = brlt_pkg::STATUS_CONFLICT;
                  res_in.blocker_id   = IdBits'(slot_owner);
                  res_in.blocker_kind = slot_kind;
                  state_in            = brlt_pkg::ST_DONE;
               end
            end else if (idx_ff < slot_count_ff) begin
               rd_en      = 1'b1;
               chk_idx_in = idx_ff[ADDR_BITS-1:0];
               chk_vld_in = 1'b1;
               idx_in     = idx_ff + COUNT_BITS'(1);
            end else begin
               chk_vld_in = 1'b0;
               state_in   = brlt_pkg::ST_DONE;
               if (req_mode == brlt_pkg::MODE_ACQUIRE) begin
                  if (slot_count_ff == COUNT_BITS'(DEPTH)) begin
                     res_in.status = brlt_pkg::STATUS_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     wr_addr       = slot_count_ff[ADDR_BITS-1:0];
                     wr_data       = req_entry;
                     slot_count_in = slot_count_ff + COUNT_BITS'(1);
                  end
               end
            end
         end

         brlt_pkg::ST_SHIFT: begin
            // read entry j, write it to j-1 in the next cycle
            if (wr_vld_ff) begin
               wr_en = 1'b1;
            end
            if (idx_ff < slot_count_ff) begin
               rd_en     = 1'b1;
               wr_idx_in = idx_prev[ADDR_BITS-1:0];
               wr_vld_in = 1'b1;
               idx_in    = idx_ff + COUNT_BITS'(1);
            end else begin
               wr_vld_in = 1'b0;
               if (!wr_vld_ff) begin
                  slot_count_in = last_idx;
                  state_in      = brlt_pkg::ST_DONE;
               end
            end
         end

         brlt_pkg::ST_RA_READ: begin
            if (idx_ff >= slot_count_ff) begin
               state_in = brlt_pkg::ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = brlt_pkg::ST_RA_CHECK;
            end
         end

         brlt_pkg::ST_RA_CHECK: begin
            if (match.same_owner) begin
               rd_en    = 1'b1;
               rd_addr  = last_idx[ADDR_BITS-1:0];
               state_in = brlt_pkg::ST_RA_MOVE;
            end else begin
               idx_in   = idx_ff + COUNT_BITS'(1);
               state_in = brlt_pkg::ST_RA_READ;
            end
         end

         brlt_pkg::ST_RA_MOVE: begin
            // fill the hole with the last entry, then look at the same slot again
            wr_en         = 1'b1;
            wr_addr       = idx_ff[ADDR_BITS-1:0];
            slot_count_in = last_idx;
            state_in      = brlt_pkg::ST_RA_READ;
         end

         brlt_pkg::ST_DONE: begin
            res_vld = 1'b1;
            if (res_rdy) begin
               state_in = brlt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = brlt_pkg::ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      slot_count_ff <= COUNT_BITS'(DEPTH))
      else $error("lock count exceeds table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (slot_count_ff != $past(slot_count_ff)) |->
         ((slot_count_ff == $past(slot_count_ff) + COUNT_BITS'(1)) ||
          (slot_count_ff == $past(slot_count_ff) - COUNT_BITS'(1))))
      else $error("lock count moved by more than one");

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write of the same entry in one cycle");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (res_vld && (res.status == brlt_pkg::STATUS_FULL)) |->
         (slot_count_ff == COUNT_BITS'(DEPTH)))
      else $error("full status with free entries");

endmodule

`default_nettype wire

// ----- sv/byte_range_lock_table.sv -----
// Top level of the byte-range lock table: stream ports, request capture and result register.
`default_nettype none

// Byte-range lock table. Each transaction on the req_ side carries one request
// (acquire, release exact range, release all of an owner, or test) and yields
// exactly one transaction on the rsp_ side with a status and, on a conflict,
// the owner and kind of the first conflicting lock. Entries live in a single
// memory with one read and one write port and registered read data. The scan
// and the shift-down walk that memory one entry per cycle through the read
// port. Acquire and test scan the stored locks; release scans for an exact
// match and, on one, shifts the tail down by one; release-all reads and checks
// each entry in turn and moves the last entry into the slot of each removed
// entry. One request is in flight at a time; a new request is taken as soon as
// the previous result is parked in the output register, even if rsp_tready is
// low, and a finished pass then waits until that register drains. Entries
// above the lock count are never read, so the memory needs no clearing after
// reset and the block is ready on the first cycle out of reset.
module byte_range_lock_table #(
   parameter int TABLE_DEPTH = 16,
   parameter int OWNER_BITS  = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // mode[1:0], owner_id[17:2], lock_kind[18], range_first[82:19],
   // range_last[146:83], zero fill[151:147]
   input  wire logic [brlt_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // status[1:0], blocker_id[17:2], blocker_kind[18], zero fill[23:19]
   output logic [brlt_pkg::RSP_TDATA_BITS-1:0]      rsp_tdata
);

   localparam int AddrBits  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CountBits = $clog2(TABLE_DEPTH + 1);
   localparam int EntryBits = OWNER_BITS + 1 + 2 * brlt_pkg::OFFSET_BITS;
   localparam int FillBits  = brlt_pkg::RSP_TDATA_BITS - 19;

   // captured request
   brlt_pkg::mode_type    req_mode_ff;
   logic [OWNER_BITS-1:0] req_key_ff;
   logic                  req_kind_ff;
   brlt_pkg::offset_type  req_first_ff;
   brlt_pkg::offset_type  req_last_ff;

   // result register
   logic                  rsp_tvalid_ff;
   brlt_pkg::result_type  rsp_res_ff;

   logic                  req_accept;
   logic                  seq_idle;
   logic                  res_vld;
   logic                  res_rdy;
   brlt_pkg::result_type  res;

   logic                  rd_en;
   logic [AddrBits-1:0]   rd_addr;
   logic [EntryBits-1:0]  rd_data;
   logic                  wr_en;
   logic [AddrBits-1:0]   wr_addr;
   logic [EntryBits-1:0]  wr_data;

   assign req_tready = seq_idle;
   assign req_accept = req_tvalid && req_tready;

   // the output slot is free when empty or being drained this cycle
   assign res_rdy = !rsp_tvalid_ff || rsp_tready;

   // hold the request fields for the whole pass
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_mode_ff  <= brlt_pkg::mode_type'(req_tdata[1:0]);
         req_key_ff   <= OWNER_BITS'(req_tdata[17:2]);
         req_kind_ff  <= req_tdata[18];
         req_first_ff <= req_tdata[82:19];
         req_last_ff  <= req_tdata[146:83];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (res_vld && res_rdy) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_vld && res_rdy) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{FillBits{1'b0}}, rsp_res_ff.blocker_kind,
                        rsp_res_ff.blocker_id, rsp_res_ff.status};

   brlt_store #(
      .DEPTH     (TABLE_DEPTH),
      .ADDR_BITS (AddrBits),
      .DATA_BITS (EntryBits)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   brlt_seq #(
      .DEPTH      (TABLE_DEPTH),
      .OWNER_BITS (OWNER_BITS),
      .ADDR_BITS  (AddrBits),
      .COUNT_BITS (CountBits),
      .ENTRY_BITS (EntryBits)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .idle      (seq_idle),
      .req_mode  (req_mode_ff),
      .req_key   (req_key_ff),
      .req_kind  (req_kind_ff),
      .req_first (req_first_ff),
      .req_last  (req_last_ff),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .res_vld   (res_vld),
      .res_rdy   (res_rdy),
      .res       (res)
   );

endmodule

`default_nettype wire
